// ===== hw/rtl/tsd_pkg.sv =====
`timescale 1ns / 1ps
// transient slice detector: shared types, codes and constants
// used by every module of the block but tsd_ram, depends on nothing
package tsd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 18;
	localparam int FRAME_W   = 17;
	localparam int INDEX_W   = 13;
	localparam int ENV_W     = 24;
	localparam int DIV_W     = 26;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_DETECT = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_CAPACITY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_MILLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd5;

	localparam logic [3:0]  RST_CHANNELS  = 4'd1;
	localparam logic [17:0] RST_SPACING   = 18'd256;
	localparam logic [9:0]  RST_PER_MILLE = 10'd250;
	localparam logic [3:0]  RST_SHIFT     = 4'd4;
	localparam logic [12:0] RST_RADIUS    = 13'd64;
	localparam logic [12:0] RST_CAPACITY  = 13'd4096;

	localparam logic [9:0]  PER_MILLE_MAX = 10'd1000;
	localparam logic [3:0]  SHIFT_MAX     = 4'd12;
	localparam logic [12:0] RADIUS_MAX    = 13'd4096;
	localparam logic [10:0] DIVISOR       = 11'd1000;
	localparam logic [9:0]  ROUND_UP      = 10'd999;

	// divide by 1000 as a shift by 3 and a reciprocal multiply for 125
	localparam logic [22:0] RECIP_125   = 23'd4294968;
	localparam int          RECIP_SHIFT = 29;

	typedef struct packed {
		logic [1:0]                 func;
		logic signed [SAMPLE_W-1:0] sample;
	} tsd_req_t;

	typedef struct packed {
		logic               marker_valid;
		logic [FRAME_W-1:0] marker_frame;
		logic [INDEX_W-1:0] marker_index;
		logic               last;
		logic [1:0]         status;
	} tsd_res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_MUL, ST_DIV, ST_FIRST, ST_AMP_RD, ST_AMP_ACC,
		ST_DECIDE, ST_CAND, ST_XA, ST_XB, ST_XCMP, ST_TAKE, ST_ENV, ST_DONE
	} tsd_state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic init;
		logic mul;
		logic div;
		logic first;
		logic amp_acc;
		logic decide;
		logic cand_pick;
		logic cand_next;
		logic chan_inc;
		logic xa_latch;
		logic snap_hit;
		logic snap_miss;
		logic take;
		logic env;
		logic rd_prev;
		logic rd_cur;
	} tsd_cmd_t;

	typedef struct packed {
		logic halted;
		logic invalid;
		logic is_first;
		logic cap_ok;
		logic chan_last;
		logic fire;
		logic spaced;
		logic eligible;
		logic cand_zero;
		logic cross_fail;
		logic radius_end;
	} tsd_stat_t;

endpackage

// ===== hw/rtl/transient_slice_detector.sv =====
`timescale 1ns / 1ps
// transient slice detector top level: controller plus datapath
// depends on tsd_pkg, tsd_ctrl, tsd_datapath
//
// usage: a request is taken when start is high and busy is low. func load
// writes one sample to the store and clear resets the detection state; both
// are done in idle and busy stays low, so they may be issued every cycle.
// func detect handles the next frame and gives exactly one result on res,
// marked by done for one cycle; the receiver cannot stall it.
// detect checks the settings, scales the threshold, reads every channel of
// the frame for its amplitude and, for a new marker, searches for a zero
// crossing within the radius, all through the single read port of the sample
// store. the next request is taken in the cycle after done.
// invalid settings or a halted block go from the check straight to done.
// settings must be written through cfg_we, cfg_index, cfg_data while idle;
// the user is bound by this, the block does not enforce it. reset clears
// the block state and loads the default settings; the store and n_q, amp_q,
// a_q, m_q have no reset, and only written store entries are ever read.
module transient_slice_detector #(
	parameter int MAX_SAMPLES  = 131072,
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_MARKERS  = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tsd_pkg::tsd_req_t             req,
	output logic                          done,
	output tsd_pkg::tsd_res_t             res,
	input  logic                          cfg_we,
	input  logic [tsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsd_pkg::CFG_W-1:0]     cfg_data
);
	import tsd_pkg::*;

	tsd_cmd_t  cmd;
	tsd_stat_t stat;

	tsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tsd_datapath #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_MARKERS  (MAX_MARKERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);
endmodule

// ===== hw/rtl/tsd_ram.sv =====
`timescale 1ns / 1ps
// generic single-port ram with registered read
// no dependencies
module tsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/tsd_datapath.sv =====
`timescale 1ns / 1ps
// transient slice detector datapath: settings, sample store, threshold divider,
// envelope follower and zero-crossing search; depends on tsd_pkg and tsd_ram
module tsd_datapath #(
	parameter int MAX_SAMPLES  = 131072,
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_MARKERS  = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tsd_pkg::tsd_req_t                  req,
	input  tsd_pkg::tsd_cmd_t                  cmd,
	output tsd_pkg::tsd_stat_t                 stat,
	input  logic                               cfg_we,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsd_pkg::CFG_W-1:0]          cfg_data,
	output tsd_pkg::tsd_res_t                  res
);
	import tsd_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int LW = $clog2(MAX_SAMPLES + 1);
	localparam int WW = (LW > 18 ? LW : 18) + 2;
	localparam int PW = WW + 4;
	localparam logic [LW-1:0] SampleMax = LW'(MAX_SAMPLES);
	localparam logic [4:0]    ChanMax   = 5'(MAX_CHANNELS);
	localparam logic [13:0]   MarkMax   = 14'(MAX_MARKERS);

	// settings
	logic [3:0]  cc_q;
	logic [17:0] spacing_q;
	logic [9:0]  tpm_q;
	logic [3:0]  shift_q;
	logic [12:0] radius_q;
	logic [12:0] capacity_q;

	// block state
	logic [LW-1:0]      loaded_q;
	logic [15:0]        peak_q;
	logic [ENV_W-1:0]   env_q;
	logic [LW-1:0]      last_q;
	logic               armed_q;
	logic [INDEX_W-1:0] total_q;
	logic [LW-1:0]      pos_q;
	logic               halted_q;

	// step work registers
	logic [15:0]        thr_q;
	logic [3:0]         chan_q;
	logic [12:0]        d_q;
	logic               up_q;
	logic               valid_q;
	logic [LW-1:0]      mframe_q;
	logic               lastf_q;
	logic [1:0]         status_q;
	logic [DIV_W-1:0]   n_q;
	logic [15:0]        amp_q;
	logic [15:0]        a_q;
	logic [LW-1:0]      m_q;

	logic [PW-1:0]    loaded_w;
	logic [WW-1:0]    pos_w;
	logic [WW-1:0]    d_w;
	logic [WW-1:0]    cand;
	logic [WW-1:0]    lower;
	logic [WW-1:0]    rd_frame;
	logic [PW-1:0]    p_next;
	logic [PW-1:0]    p_last;
	logic [PW-1:0]    p_upend;
	logic [PW-1:0]    rd_idx;
	logic [AW-1:0]    ram_addr;
	logic             ram_we;
	logic [15:0]      rdata;
	logic [15:0]      rd_abs;
	logic [15:0]      in_abs;
	logic [15:0]      baseline;
	logic [15:0]      attack;
	logic             rearm;
	logic [13:0]      total_inc;
	logic [RECIP_SHIFT+15:0] recip;
	logic [15:0]      quot;
	logic [DIV_W-1:0] prod;
	logic [ENV_W-1:0] target;
	logic [ENV_W-1:0] env_next;
	logic             can_load;

	assign loaded_w = PW'(loaded_q);
	assign pos_w    = WW'(pos_q);
	assign d_w      = WW'(d_q);
	assign cand     = up_q ? pos_w + d_w : pos_w - d_w;
	assign lower    = WW'(last_q) + WW'(spacing_q);
	assign p_next   = PW'(pos_w + WW'(1)) * PW'(cc_q);
	assign p_last   = PW'(pos_w + WW'(2)) * PW'(cc_q);
	assign p_upend  = PW'(cand + WW'(1)) * PW'(cc_q);
	assign rd_frame = cmd.rd_prev ? cand - WW'(1) : (cmd.rd_cur ? cand : pos_w);
	assign rd_idx   = PW'(rd_frame) * PW'(cc_q) + PW'(chan_q);

	assign can_load = cmd.load && (loaded_q < SampleMax);
	assign ram_we   = can_load;
	assign ram_addr = cmd.load ? loaded_q[AW-1:0] : rd_idx[AW-1:0];

	tsd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.sample),
		.rdata (rdata)
	);

	assign rd_abs   = rdata[15] ? (~rdata + 16'd1) : rdata;
	assign in_abs   = req.sample[15] ? (~req.sample + 16'd1) : req.sample;
	assign baseline = env_q[ENV_W-1:8];
	assign attack   = (amp_q > baseline) ? amp_q - baseline : 16'd0;
	assign rearm    = attack < ((thr_q >> 1) + 16'd1);
	assign total_inc = {1'b0, total_q} + 14'd1;

	assign prod     = DIV_W'(peak_q) * DIV_W'(tpm_q);
	assign recip    = (RECIP_SHIFT+16)'(n_q[DIV_W-1:3]) * (RECIP_SHIFT+16)'(RECIP_125);
	assign quot     = recip[RECIP_SHIFT+15:RECIP_SHIFT];

	assign target   = {amp_q, 8'h00};
	assign env_next = (target >= env_q) ? env_q + ((target - env_q) >> shift_q)
	                                    : env_q - ((env_q - target) >> shift_q);

	always_comb begin
		stat.halted   = halted_q;
		stat.invalid  = (cc_q == 4'd0) || ({1'b0, cc_q} > ChanMax) || (spacing_q == 18'd0)
			|| (tpm_q == 10'd0) || (tpm_q > PER_MILLE_MAX) || (shift_q == 4'd0)
			|| (shift_q > SHIFT_MAX) || (radius_q > RADIUS_MAX)
			|| (loaded_w < PW'(cc_q)) || (p_next > loaded_w);
		stat.is_first  = pos_q == '0;
		stat.cap_ok    = (total_inc <= {1'b0, capacity_q}) && (total_inc <= MarkMax);
		stat.chan_last = chan_q == cc_q - 4'd1;
		stat.fire      = (attack >= thr_q) && armed_q;
		stat.spaced    = (pos_w >= WW'(last_q)) && (pos_w - WW'(last_q) >= WW'(spacing_q));
		stat.eligible  = up_q ? ((d_q != 13'd0) && (p_upend <= loaded_w))
		                      : ((d_w <= pos_w) && (cand >= lower));
		stat.cand_zero = cand == '0;
		stat.cross_fail = (cand == '0) ? (rdata != 16'd0)
			: ((a_q != 16'd0) && (rdata != 16'd0) && (a_q[15] == rdata[15]));
		stat.radius_end = up_q && (d_q == radius_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q       <= RST_CHANNELS;
			spacing_q  <= RST_SPACING;
			tpm_q      <= RST_PER_MILLE;
			shift_q    <= RST_SHIFT;
			radius_q   <= RST_RADIUS;
			capacity_q <= RST_CAPACITY;
			loaded_q   <= '0;
			peak_q     <= '0;
			env_q      <= '0;
			last_q     <= '0;
			armed_q    <= 1'b1;
			total_q    <= '0;
			pos_q      <= '0;
			halted_q   <= 1'b0;
			thr_q      <= '0;
			chan_q     <= '0;
			d_q        <= '0;
			up_q       <= 1'b0;
			valid_q    <= 1'b0;
			mframe_q   <= '0;
			lastf_q    <= 1'b0;
			status_q   <= STAT_OK;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNELS:  cc_q       <= cfg_data[3:0];
					CFG_SPACING:   spacing_q  <= cfg_data[17:0];
					CFG_PER_MILLE: tpm_q      <= cfg_data[9:0];
					CFG_SHIFT:     shift_q    <= cfg_data[3:0];
					CFG_RADIUS:    radius_q   <= cfg_data[12:0];
					CFG_CAPACITY:  capacity_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (can_load) begin
				loaded_q <= loaded_q + LW'(1);
				if (in_abs > peak_q) begin
					peak_q <= in_abs;
				end
			end
			if (cmd.clear) begin
				loaded_q <= '0;
				peak_q   <= '0;
				env_q    <= '0;
				last_q   <= '0;
				armed_q  <= 1'b1;
				total_q  <= '0;
				pos_q    <= '0;
				halted_q <= 1'b0;
			end
			if (cmd.init) begin
				valid_q  <= 1'b0;
				mframe_q <= '0;
				lastf_q  <= 1'b0;
				status_q <= halted_q ? STAT_CAPACITY : (stat.invalid ? STAT_INVALID : STAT_OK);
			end
			if (cmd.first) begin
				thr_q  <= (n_q[15:0] == 16'd0) ? 16'd1 : n_q[15:0];
				chan_q <= '0;
				if (pos_q == '0) begin
					if (stat.cap_ok) begin
						valid_q  <= 1'b1;
						mframe_q <= '0;
						total_q  <= total_q + INDEX_W'(1);
					end else begin
						halted_q <= 1'b1;
						status_q <= STAT_CAPACITY;
					end
				end
			end
			if (cmd.amp_acc || cmd.chan_inc) begin
				chan_q <= chan_q + 4'd1;
			end
			if (cmd.decide) begin
				d_q  <= '0;
				up_q <= 1'b0;
				if (stat.fire) begin
					armed_q <= 1'b0;
				end else if (rearm) begin
					armed_q <= 1'b1;
				end
			end
			if (cmd.cand_pick) begin
				chan_q <= '0;
			end
			if (cmd.cand_next) begin
				if (up_q) begin
					up_q <= 1'b0;
					d_q  <= d_q + 13'd1;
				end else begin
					up_q <= 1'b1;
				end
			end
			if (cmd.take) begin
				if (stat.cap_ok) begin
					valid_q  <= 1'b1;
					mframe_q <= m_q;
					last_q   <= m_q;
					total_q  <= total_q + INDEX_W'(1);
				end else begin
					halted_q <= 1'b1;
					status_q <= STAT_CAPACITY;
				end
			end
			if (cmd.env) begin
				env_q <= env_next;
				if (!halted_q) begin
					lastf_q <= p_last > loaded_w;
					pos_q   <= pos_q + LW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			n_q <= prod + DIV_W'(ROUND_UP);
		end
		if (cmd.div) begin
			n_q <= DIV_W'(quot);
		end
		if (cmd.first) begin
			amp_q <= '0;
		end
		if (cmd.amp_acc && (rd_abs > amp_q)) begin
			amp_q <= rd_abs;
		end
		if (cmd.xa_latch) begin
			a_q <= rdata;
		end
		if (cmd.snap_hit) begin
			m_q <= LW'(cand);
		end
		if (cmd.snap_miss) begin
			m_q <= pos_q;
		end
	end

	always_comb begin
		res.marker_valid = valid_q;
		res.marker_frame = FRAME_W'(mframe_q);
		res.marker_index = total_q;
		res.last         = lastf_q;
		res.status       = status_q;
	end
endmodule

// ===== hw/rtl/tsd_ctrl.sv =====
`timescale 1ns / 1ps
// transient slice detector controller: request decode and detect sequencer
// depends on tsd_pkg
module tsd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         func,
	input  tsd_pkg::tsd_stat_t stat,
	output tsd_pkg::tsd_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import tsd_pkg::*;

	tsd_state_t state_q;
	tsd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_DETECT) state_d = ST_CHECK;
			end
			ST_CHECK:   state_d = (stat.halted || stat.invalid) ? ST_DONE : ST_MUL;
			ST_MUL:     state_d = ST_DIV;
			ST_DIV:     state_d = ST_FIRST;
			ST_FIRST:   state_d = (stat.is_first && !stat.cap_ok) ? ST_DONE : ST_AMP_RD;
			ST_AMP_RD:  state_d = ST_AMP_ACC;
			ST_AMP_ACC: state_d = stat.chan_last ? ST_DECIDE : ST_AMP_RD;
			ST_DECIDE:  state_d = (stat.fire && stat.spaced) ? ST_CAND : ST_ENV;
			ST_CAND: begin
				if (stat.eligible) state_d = stat.cand_zero ? ST_XB : ST_XA;
				else if (stat.radius_end) state_d = ST_TAKE;
			end
			ST_XA:      state_d = ST_XB;
			ST_XB:      state_d = ST_XCMP;
			ST_XCMP: begin
				if (stat.cross_fail) state_d = stat.radius_end ? ST_TAKE : ST_CAND;
				else if (stat.chan_last) state_d = ST_TAKE;
				else state_d = stat.cand_zero ? ST_XB : ST_XA;
			end
			ST_TAKE:    state_d = ST_ENV;
			ST_ENV:     state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = state_q != ST_IDLE;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load  = start && func == FUNC_LOAD;
				cmd.clear = start && func == FUNC_CLEAR;
			end
			ST_CHECK:   cmd.init = 1'b1;
			ST_MUL:     cmd.mul = 1'b1;
			ST_DIV:     cmd.div = 1'b1;
			ST_FIRST:   cmd.first = 1'b1;
			ST_AMP_ACC: cmd.amp_acc = 1'b1;
			ST_DECIDE:  cmd.decide = 1'b1;
			ST_CAND: begin
				if (stat.eligible) cmd.cand_pick = 1'b1;
				else if (stat.radius_end) cmd.snap_miss = 1'b1;
				else cmd.cand_next = 1'b1;
			end
			ST_XA:      cmd.rd_prev = 1'b1;
			ST_XB: begin
				cmd.xa_latch = 1'b1;
				cmd.rd_cur   = 1'b1;
			end
			ST_XCMP: begin
				if (stat.cross_fail) begin
					if (stat.radius_end) cmd.snap_miss = 1'b1;
					else cmd.cand_next = 1'b1;
				end else if (stat.chan_last) begin
					cmd.snap_hit = 1'b1;
				end else begin
					cmd.chan_inc = 1'b1;
					cmd.rd_prev  = !stat.cand_zero;
					cmd.rd_cur   = 1'b0;
				end
			end
			ST_TAKE:    cmd.take = 1'b1;
			ST_ENV:     cmd.env = 1'b1;
			ST_DONE:    done = 1'b1;
			default: ;
		endcase
	end
endmodule
